>>> rtl/core/hcv_pkg.sv
`timescale 1ns / 1ps
package hcv_pkg;

  // Default geometry of the accumulator.
  localparam int IMG_ROWS_DEF  = 64;
  localparam int IMG_COLS_DEF  = 64;
  localparam int NUM_RADII_DEF = 32;
  localparam int NUM_ANGLES    = 360;

  // Fixed field and datapath widths.
  localparam int ROW_W   = 6;
  localparam int COL_W   = 6;
  localparam int EDGE_W  = 8;
  localparam int RIDX_W  = 5;
  localparam int REQ_W   = 2;
  localparam int CNT_W   = 8;
  localparam int THR_W   = 8;
  localparam int MINR_W  = 6;
  localparam int RCNT_W  = 6;
  localparam int CFG_W   = 8;
  localparam int CIDX_W  = 2;
  localparam int RAD_W   = 9;   // radius and radius count; radius up to 63 + (NUM_RADII - 1)
  localparam int ANG_W   = 9;
  localparam int TRIG_W  = 16;  // signed Q2.14
  localparam int FRAC    = 14;
  localparam int PROD_W  = RAD_W + 1 + TRIG_W;
  localparam int POS_W   = 28;  // signed centre coordinate in Q14
  localparam int IN_DW   = 32;
  localparam int OUT_DW  = 16;

  localparam logic [ANG_W-1:0]  ANG_QUARTER = 9'd90;
  localparam logic [ANG_W-1:0]  ANG_HALF    = 9'd180;
  localparam logic [ANG_W-1:0]  ANG_THREE_Q = 9'd270;
  localparam logic [ANG_W-1:0]  ANG_FULL    = 9'd360;
  localparam logic [CNT_W-1:0]  CNT_SAT     = 8'd255;
  localparam logic [EDGE_W-1:0] EDGE_ON     = 8'd255;

  // Request kinds.
  localparam logic [REQ_W-1:0] REQ_VOTE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  // Register indexes and reset values.
  localparam logic [CIDX_W-1:0] REG_THRESH = 2'd0;
  localparam logic [CIDX_W-1:0] REG_MINR   = 2'd1;
  localparam logic [CIDX_W-1:0] REG_RCNT   = 2'd2;
  localparam logic [THR_W-1:0]  THRESH_RST = 8'd140;
  localparam logic [MINR_W-1:0] MINR_RST   = 6'd8;
  localparam logic [RCNT_W-1:0] RCNT_RST   = 6'd32;

  // round(16384 * sin(d degrees)) for d = 0..90.
  localparam logic [14:0] SIN_TBL [0:90] = '{
    15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
    15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
    15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
    15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
    15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
    15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
    15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
    15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
    15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
    15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
    15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
    15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
    15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
  };

  // Sine of a whole-degree angle 0..359, folded onto the first quadrant.
  function automatic logic signed [TRIG_W-1:0] sin_q14(input logic [ANG_W-1:0] t);
    logic [ANG_W-1:0] d;
    logic             neg;
    logic signed [TRIG_W-1:0] mag;
    d   = t;
    neg = 1'b0;
    priority if (t <= ANG_QUARTER) begin
      d = t;
    end else if (t <= ANG_HALF) begin
      d = ANG_HALF - t;
    end else if (t <= ANG_THREE_Q) begin
      d   = t - ANG_HALF;
      neg = 1'b1;
    end else begin
      d   = ANG_FULL - t;
      neg = 1'b1;
    end
    mag = signed'({1'b0, SIN_TBL[d[6:0]]});
    return neg ? -mag : mag;
  endfunction

  typedef struct packed {
    logic start;     // latch the item, reset sweep counters
    logic trig_ld;   // load sine and cosine of the current angle
    logic mul;       // radius times sine and cosine
    logic addr_ld;   // centre position, bounds and cell address
    logic rd;        // read accumulator cell
    logic wr;        // write back incremented cell
    logic rs_inc;    // next radius
    logic ang_next;  // next angle, radius back to zero
    logic clr_wr;    // zero one cell of the clearing sweep
    logic out_load;  // load the query result into the output register
  } cmd_t;

  typedef struct packed {
    logic vote_go;
    logic rad_last;
    logic ang_last;
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/core/hough_circle_voter.sv
`timescale 1ns / 1ps
// Hough circle voting engine with an on-chip accumulator of
// IMG_ROWS x IMG_COLS x NUM_RADII saturating 8-bit cells.
// Input channel: in_tuser carries the request kind (vote, query, clear) and
// in_tdata the pixel position, edge value and radius index. Only a query
// produces a transfer on the output channel (count and circle flag).
// A vote with edge value 255 and a nonzero radius count sweeps 360 angles;
// per angle it loads sine and cosine, then takes each radius through
// multiply, address, read and write back on the single accumulator port
// pair, for R = min(radius_count, NUM_RADII) radii. Other votes are dropped.
// A query reads its cell, then loads the result into the output register;
// a clear sweeps one cell per cycle over all IMG_ROWS * IMG_COLS * NUM_RADII
// cells (131,072 with the default sizes). The block takes one item at a time.
// After reset the same clearing sweep runs before in_tready rises;
// configuration writes are taken during it. A stalled receiver holds the
// result in the output register; the block still accepts the next item and
// only a second query waits until the first result has been taken.
module hough_circle_voter #(
  parameter int IMG_ROWS  = hcv_pkg::IMG_ROWS_DEF,
  parameter int IMG_COLS  = hcv_pkg::IMG_COLS_DEF,
  parameter int NUM_RADII = hcv_pkg::NUM_RADII_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [hcv_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [hcv_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // from bit 0: pixel_row[5:0], pixel_col[11:6], edge_value[19:12],
  // radius_index[24:20], zero fill
  input  logic [hcv_pkg::IN_DW-1:0]   in_tdata,
  // req_type[1:0]
  input  logic [hcv_pkg::REQ_W-1:0]   in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // from bit 0: vote_count[7:0], circle_found[8], zero fill
  output logic [hcv_pkg::OUT_DW-1:0]  out_tdata
);
  import hcv_pkg::*;

  cmd_t             cmd;
  sts_t             sts;
  logic [CNT_W-1:0] vote_count;
  logic             circle_found;

  hcv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .req_type  (in_tuser),
    .sts       (sts),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  hcv_datapath #(
    .IMG_ROWS  (IMG_ROWS),
    .IMG_COLS  (IMG_COLS),
    .NUM_RADII (NUM_RADII)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .pixel_row    (in_tdata[5:0]),
    .pixel_col    (in_tdata[11:6]),
    .edge_value   (in_tdata[19:12]),
    .radius_index (in_tdata[24:20]),
    .cmd          (cmd),
    .sts          (sts),
    .out_tready   (out_tready),
    .out_tvalid   (out_tvalid),
    .vote_count   (vote_count),
    .circle_found (circle_found)
  );

  assign out_tdata = {(OUT_DW - CNT_W - 1)'(0), circle_found, vote_count};

`ifndef NO_ASSERTIONS
  // A pending result is never overwritten by the next query.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid || out_tready))
    else $error("query result loaded over an untaken result");

  // Clearing sweep and vote write-back never share the write port.
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_wr |-> !cmd.wr)
    else $error("clear and vote write in the same cycle");

  // An accepted query keeps the input side closed while it reads.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == REQ_QUERY)) |=> !in_tready)
    else $error("input accepted during a query");
`endif

endmodule

>>> rtl/core/hcv_ctrl.sv
`timescale 1ns / 1ps
module hcv_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  input  logic [hcv_pkg::REQ_W-1:0] req_type,
  input  hcv_pkg::sts_t             sts,
  output logic                      in_tready,
  output hcv_pkg::cmd_t             cmd
);
  import hcv_pkg::*;

  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_ANG  = 4'd2;
  localparam logic [3:0] ST_MUL  = 4'd3;
  localparam logic [3:0] ST_ADDR = 4'd4;
  localparam logic [3:0] ST_RD   = 4'd5;
  localparam logic [3:0] ST_WR   = 4'd6;
  localparam logic [3:0] ST_QRD  = 4'd7;
  localparam logic [3:0] ST_QOUT = 4'd8;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.start = 1'b1;
          priority if (req_type == REQ_VOTE) begin
            if (sts.vote_go) state_nxt = ST_ANG;
          end else if (req_type == REQ_QUERY) begin
            state_nxt = ST_QRD;
          end else if (req_type == REQ_CLEAR) begin
            state_nxt = ST_CLR;
          end else begin
            // An unknown request kind is dropped.
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_ANG: begin
        cmd.trig_ld = 1'b1;
        state_nxt   = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_ADDR;
      end
      ST_ADDR: begin
        cmd.addr_ld = 1'b1;
        state_nxt   = ST_RD;
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_WR;
      end
      ST_WR: begin
        cmd.wr = 1'b1;
        priority if (!sts.rad_last) begin
          cmd.rs_inc = 1'b1;
          state_nxt  = ST_MUL;
        end else if (sts.ang_last) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.ang_next = 1'b1;
          state_nxt    = ST_ANG;
        end
      end
      ST_QRD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_QOUT;
      end
      ST_QOUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/hcv_datapath.sv
`timescale 1ns / 1ps
module hcv_datapath #(
  parameter int IMG_ROWS  = hcv_pkg::IMG_ROWS_DEF,
  parameter int IMG_COLS  = hcv_pkg::IMG_COLS_DEF,
  parameter int NUM_RADII = hcv_pkg::NUM_RADII_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [hcv_pkg::CIDX_W-1:0] cfg_index,
  input  logic [hcv_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic [hcv_pkg::ROW_W-1:0]  pixel_row,
  input  logic [hcv_pkg::COL_W-1:0]  pixel_col,
  input  logic [hcv_pkg::EDGE_W-1:0] edge_value,
  input  logic [hcv_pkg::RIDX_W-1:0] radius_index,
  input  hcv_pkg::cmd_t              cmd,
  output hcv_pkg::sts_t              sts,
  input  logic                       out_tready,
  output logic                       out_tvalid,
  output logic [hcv_pkg::CNT_W-1:0]  vote_count,
  output logic                       circle_found
);
  import hcv_pkg::*;

  localparam int DEPTH = IMG_ROWS * IMG_COLS * NUM_RADII;
  localparam int AW    = $clog2(DEPTH);
  localparam int RSW   = (NUM_RADII > 1) ? $clog2(NUM_RADII) : 1;
  localparam int CW    = $clog2(IMG_COLS);
  localparam int RW    = $clog2(IMG_ROWS);
  localparam logic signed [POS_W-1:0] COL_LIM = POS_W'(IMG_COLS * (2 ** FRAC));
  localparam logic signed [POS_W-1:0] ROW_LIM = POS_W'(IMG_ROWS * (2 ** FRAC));

  logic [CNT_W-1:0] mem [0:DEPTH-1];

  logic [THR_W-1:0]  thr_r;
  logic [MINR_W-1:0] minr_r;
  logic [RCNT_W-1:0] rcnt_r;

  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_r;
  logic [ANG_W-1:0] ang_r;
  logic [RSW-1:0]   rs_r;
  logic signed [TRIG_W-1:0] sin_r, cos_r;
  logic signed [PROD_W-1:0] pc_r, ps_r;
  logic [AW-1:0]    addr_r, clr_addr_r;
  logic             hit_r, q_ok_r;
  logic [CNT_W-1:0] rd_r;
  logic             out_valid_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic             out_found_r;

  logic [RAD_W-1:0] lim;
  logic [RAD_W-1:0] radius;
  logic [ANG_W-1:0] ang90;
  logic signed [POS_W-1:0] pos_a, pos_b;
  logic [CW-1:0]    ci;
  logic [RW-1:0]    ri;
  logic             hit;
  logic [AW-1:0]    vote_addr, query_addr;
  logic             query_ok;
  logic [CNT_W-1:0] q_cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THRESH_RST;
      minr_r <= MINR_RST;
      rcnt_r <= RCNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESH: thr_r  <= cfg_wdata;
        REG_MINR:   minr_r <= cfg_wdata[MINR_W-1:0];
        REG_RCNT:   rcnt_r <= cfg_wdata[RCNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign lim    = (RAD_W'(rcnt_r) > RAD_W'(NUM_RADII)) ? RAD_W'(NUM_RADII) : RAD_W'(rcnt_r);
  assign radius = RAD_W'(minr_r) + RAD_W'(rs_r);
  assign ang90  = (ang_r >= ANG_THREE_Q) ? (ang_r - ANG_THREE_Q) : (ang_r + ANG_QUARTER);

  assign pos_a = signed'(POS_W'({col_r, FRAC'(0)})) - POS_W'(pc_r);
  assign pos_b = signed'(POS_W'({row_r, FRAC'(0)})) - POS_W'(ps_r);
  assign hit   = (pos_a > 0) && (pos_a < COL_LIM) && (pos_b > 0) && (pos_b < ROW_LIM);
  assign ci    = pos_a[FRAC+CW-1:FRAC];
  assign ri    = pos_b[FRAC+RW-1:FRAC];
  assign vote_addr  = AW'((32'(ri) * IMG_COLS + 32'(ci)) * NUM_RADII + 32'(rs_r));
  assign query_addr = AW'((32'(pixel_row) * IMG_COLS + 32'(pixel_col)) * NUM_RADII
                          + 32'(radius_index));
  assign query_ok   = (32'(pixel_row) < IMG_ROWS) && (32'(pixel_col) < IMG_COLS)
                      && (32'(radius_index) < NUM_RADII);

  // Sweep counters and control-like registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_r      <= '0;
      rs_r       <= '0;
      clr_addr_r <= '0;
    end else begin
      if (cmd.start) begin
        ang_r      <= '0;
        rs_r       <= '0;
        clr_addr_r <= '0;
      end else begin
        if (cmd.rs_inc) rs_r <= rs_r + 1'b1;
        if (cmd.ang_next) begin
          ang_r <= ang_r + 1'b1;
          rs_r  <= '0;
        end
        if (cmd.clr_wr) clr_addr_r <= clr_addr_r + 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      row_r  <= pixel_row;
      col_r  <= pixel_col;
      addr_r <= query_addr;
      q_ok_r <= query_ok;
    end
    if (cmd.trig_ld) begin
      sin_r <= sin_q14(ang_r);
      cos_r <= sin_q14(ang90);
    end
    if (cmd.mul) begin
      pc_r <= signed'({1'b0, radius}) * cos_r;
      ps_r <= signed'({1'b0, radius}) * sin_r;
    end
    if (cmd.addr_ld) begin
      addr_r <= vote_addr;
      hit_r  <= hit;
    end
  end

  // Accumulator store: one read port and one write port.
  always_ff @(posedge clk) begin
    if (cmd.rd) rd_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem[clr_addr_r] <= '0;
    end else if (cmd.wr && hit_r && (rd_r != CNT_SAT)) begin
      mem[addr_r] <= rd_r + 1'b1;
    end
  end

  assign q_cnt = q_ok_r ? rd_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_cnt_r   <= q_cnt;
      out_found_r <= (q_cnt > thr_r);
    end
  end

  assign out_tvalid   = out_valid_r;
  assign vote_count   = out_cnt_r;
  assign circle_found = out_found_r;

  assign sts.vote_go  = (edge_value == EDGE_ON) && (lim != '0);
  assign sts.rad_last = (RAD_W'(rs_r) + 1'b1) == lim;
  assign sts.ang_last = (ang_r == ANG_W'(NUM_ANGLES - 1));
  assign sts.clr_last = (clr_addr_r == AW'(DEPTH - 1));
  assign sts.out_free = !out_valid_r || out_tready;

endmodule
